FILE: hdl/call_stack_exclusive_time_macros.svh
// assertion macros for the call stack exclusive time profiler
`ifndef CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH
`define CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH

`ifndef ASSERT_OFF
`define CSET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSET_ASSERT(lbl, prop, msg)
`define CSET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/cset_pkg.sv
// types, codes and defaults shared by the profiler files
package cset_pkg;

	localparam int MAX_FUNCS_DEF   = 128;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF   = 32;

	localparam logic [7:0] FUNC_COUNT_RESET = 8'd128;

	localparam logic ACT_LOG  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_EMPTY    = 2'd2,
		ERR_BAD_ID   = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOP,
		ST_NEXT,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic        action;
		logic [6:0]  func_id;
		logic        is_start;
		logic [31:0] timestamp;
		logic        first;
	} req_item_t;

	typedef struct packed {
		logic [6:0]  report_id;
		logic [31:0] report_total;
		logic        report_valid;
		logic [1:0]  error;
	} rsp_item_t;

endpackage

FILE: hdl/call_stack_exclusive_time.sv
// top level of the call stack exclusive time profiler
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req (req_item_t)
//  rsp      out  rsp_valid/rsp_ready    rsp (rsp_item_t)
//  cfg      in   cfg_valid/cfg_ready    cfg_data (function_count)
//
// an item passes through accept, stack top read, table read, update and write back
// for a log item the table address is the stack top id, so the two reads run back to back
// a result waits in the output register; the update stalls while it waits there and rsp_ready is low
// reset empties the stack and the used bits at once; no clearing pass
`include "call_stack_exclusive_time_macros.svh"

module call_stack_exclusive_time
	import cset_pkg::*;
#(
	parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int FA  = $clog2(MAX_FUNCS);
	localparam int SA  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int SW  = FA + TIME_BITS;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	state_t                 state_q, state_d;
	logic [7:0]             fc_q;
	logic [SPW-1:0]         sp_q;
	logic [MAX_FUNCS-1:0]   used_q;
	req_item_t              item_q;
	logic [TIME_BITS-1:0]   ts_q;
	err_t                   err_q;
	logic                   do_read_q;
	logic                   do_log_q;
	logic [TIME_BITS-1:0]   delta_q;
	logic [TIME_BITS-1:0]   resume_q;
	logic [FA-1:0]          tbl_addr_q;
	logic [TIME_BITS-1:0]   tot_q;
	logic [FA-1:0]          id2_q;
	rsp_item_t              rsp_q;
	logic                   rsp_valid_q;

	logic                   accept;
	logic                   load;
	logic [SPW-1:0]         sp_eff;
	logic                   bad_id;
	err_t                   err_d;
	logic [SA-1:0]          stk_raddr;
	logic [SW-1:0]          stk_rdata;
	logic                   stk_we;
	logic [SA-1:0]          stk_waddr;
	logic [SW-1:0]          stk_wdata;
	logic [FA-1:0]          top_id;
	logic [TIME_BITS-1:0]   top_time;
	logic [TIME_BITS-1:0]   diff;
	logic [TIME_BITS-1:0]   delta_d;
	logic [TIME_BITS-1:0]   resume_d;
	logic [FA-1:0]          tbl_raddr;
	logic [TIME_BITS-1:0]   tbl_rdata;
	logic                   tbl_we;
	logic [TIME_BITS-1:0]   prev;
	logic [TIME_BITS:0]     sum;
	logic [TIME_BITS-1:0]   sat_sum;
	logic                   charge;
	logic                   push;
	logic                   pop;

	cset_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	cset_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_FUNCS)) u_totals (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_addr_q),
		.wdata (tot_q),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign accept    = req_valid && req_ready;

	// checks on the incoming item, against the stack as it stands after a first clear
	always_comb begin
		sp_eff = req.first ? '0 : sp_q;
		bad_id = ({1'b0, req.func_id} >= fc_q) || (32'(req.func_id) >= 32'(MAX_FUNCS));
		if (bad_id) begin
			err_d = ERR_BAD_ID;
		end else if (req.action == ACT_READ) begin
			err_d = ERR_NONE;
		end else if (req.is_start && (sp_eff >= SPW'(STACK_DEPTH))) begin
			err_d = ERR_OVERFLOW;
		end else if (!req.is_start && (sp_eff == '0)) begin
			err_d = ERR_EMPTY;
		end else begin
			err_d = ERR_NONE;
		end
	end

	// stack top and time charge
	always_comb begin
		stk_raddr = (state_q == ST_IDLE) ? SA'(sp_q - SPW'(1)) : SA'(sp_q - SPW'(2));
		top_id    = stk_rdata[SW-1 -: FA];
		top_time  = stk_rdata[TIME_BITS-1:0];
		diff      = (ts_q >= top_time) ? (ts_q - top_time) : '0;
		if (item_q.is_start || (diff == TIME_MAX)) begin
			delta_d = diff;
		end else begin
			delta_d = diff + TIME_BITS'(1);
		end
		resume_d  = (ts_q == TIME_MAX) ? ts_q : (ts_q + TIME_BITS'(1));
		tbl_raddr = (item_q.action == ACT_READ) ? FA'(item_q.func_id) : top_id;
	end

	// saturating total update
	always_comb begin
		prev    = used_q[tbl_addr_q] ? tbl_rdata : '0;
		sum     = {1'b0, prev} + {1'b0, delta_q};
		sat_sum = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	end

	// write back
	always_comb begin
		charge    = do_log_q && (sp_q != '0);
		push      = load && do_log_q && item_q.is_start;
		pop       = load && do_log_q && !item_q.is_start;
		tbl_we    = load && charge;
		stk_we    = 1'b0;
		stk_waddr = SA'(sp_q);
		stk_wdata = {FA'(item_q.func_id), ts_q};
		if (push) begin
			stk_we = 1'b1;
		end else if (pop && (sp_q > SPW'(1))) begin
			stk_we    = 1'b1;
			stk_waddr = SA'(sp_q - SPW'(2));
			stk_wdata = {id2_q, resume_q};
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_TOP;
				end
			end
			ST_TOP: begin
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				if (!rsp_valid_q || rsp_ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= FUNC_COUNT_RESET;
			sp_q        <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fc_q <= cfg_data;
			end
			if (accept && req.first) begin
				sp_q   <= '0;
				used_q <= '0;
			end
			if (push) begin
				sp_q <= sp_q + SPW'(1);
			end else if (pop) begin
				sp_q <= sp_q - SPW'(1);
			end
			if (tbl_we) begin
				used_q[tbl_addr_q] <= 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= req;
			ts_q      <= TIME_BITS'(req.timestamp);
			err_q     <= err_d;
			do_read_q <= (err_d == ERR_NONE) && (req.action == ACT_READ);
			do_log_q  <= (err_d == ERR_NONE) && (req.action == ACT_LOG);
		end
		if (state_q == ST_TOP) begin
			delta_q    <= delta_d;
			resume_q   <= resume_d;
			tbl_addr_q <= tbl_raddr;
		end
		if (state_q == ST_NEXT) begin
			tot_q <= do_read_q ? prev : sat_sum;
			id2_q <= stk_rdata[SW-1 -: FA];
		end
		if (load) begin
			rsp_q.report_valid <= do_read_q || charge;
			rsp_q.report_id    <= (do_read_q || charge) ? 7'(tbl_addr_q) : '0;
			rsp_q.report_total <= (do_read_q || charge) ? 32'(tot_q) : '0;
			rsp_q.error        <= err_q;
		end
	end

	`CSET_ASSERT(a_sp_bound, sp_q <= SPW'(STACK_DEPTH), "stack pointer beyond depth")
	`CSET_ASSERT(a_rsp_from_calc, $rose(rsp_valid) |-> $past(state_q == ST_CALC), "result not from update")
	`CSET_ASSERT(a_valid_no_err, rsp_valid && rsp.report_valid |-> rsp.error == ERR_NONE, "report with error")
	`CSET_ASSERT_NEXT(a_push_sp, push, sp_q == $past(sp_q) + SPW'(1), "push did not grow stack")

endmodule

FILE: hdl/cset_ram.sv
// generic single write port ram with registered read
module cset_ram
	import cset_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
